// ===== rtl/sgt_pkg.sv =====
// shared types and constants for the stack graph traversal core
package sgt_pkg;

   // default sizing of the graph store
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_DEGREE_DEF   = 16;

   // fixed field widths
   localparam int VERTEX_W  = 6;
   localparam int COUNT_W   = 7;
   localparam int OPCODE_W  = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 1;

   // vertex_count after reset
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = COUNT_W'(64);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VERTEX_COUNT = 1'd0,
      CSR_START_VERTEX = 1'd1
   } csr_index_type;

   // request opcodes
   typedef enum logic [OPCODE_W-1:0] {
      OP_CLEAR    = 2'd0,
      OP_ADD_EDGE = 2'd1,
      OP_TRAVERSE = 2'd2
   } opcode_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_STORED  = 2'd0,
      ST_DROPPED = 2'd1,
      ST_VISIT   = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   // command kinds after classification in the front end
   typedef enum logic [2:0] {
      CMD_CLEAR,
      CMD_EDGE,
      CMD_EDGE_BAD,
      CMD_WALK,
      CMD_WALK_BAD
   } cmd_kind_type;

   // queued command; a walk carries its start vertex in from_vertex
   typedef struct packed {
      cmd_kind_type          kind;
      logic [VERTEX_W-1:0]   from_vertex;
      logic [VERTEX_W-1:0]   to_vertex;
   } cmd_type;

endpackage

// ===== rtl/sgt_front.sv =====
// request front end: accept, range classification and command queue
module sgt_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [sgt_pkg::OPCODE_W-1:0]  req_opcode,
   input  logic [sgt_pkg::VERTEX_W-1:0]  req_from_vertex,
   input  logic [sgt_pkg::VERTEX_W-1:0]  req_to_vertex,
   input  logic [sgt_pkg::COUNT_W-1:0]   active_count,
   input  logic [sgt_pkg::VERTEX_W-1:0]  start_vertex,
   output logic                          q_valid,
   output sgt_pkg::cmd_type              q_cmd,
   input  logic                          q_pop
);

   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);

   sgt_pkg::cmd_type  queue_ff [QDEPTH];
   logic [QPW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]      fill_ff, fill_in;

   sgt_pkg::cmd_type  new_cmd;
   logic              new_ok;
   logic              accept;
   logic              push;

   // classify the incoming request against the active vertex range
   always_comb begin
      new_cmd.from_vertex = req_from_vertex;
      new_cmd.to_vertex   = req_to_vertex;
      new_cmd.kind        = sgt_pkg::CMD_CLEAR;
      new_ok              = 1'b1;
      unique case (req_opcode)
         sgt_pkg::OP_CLEAR: begin
            new_cmd.kind = sgt_pkg::CMD_CLEAR;
         end
         sgt_pkg::OP_ADD_EDGE: begin
            if ((sgt_pkg::COUNT_W'(req_from_vertex) < active_count) &&
                (sgt_pkg::COUNT_W'(req_to_vertex) < active_count)) begin
               new_cmd.kind = sgt_pkg::CMD_EDGE;
            end else begin
               new_cmd.kind = sgt_pkg::CMD_EDGE_BAD;
            end
         end
         sgt_pkg::OP_TRAVERSE: begin
            new_cmd.from_vertex = start_vertex;
            if (sgt_pkg::COUNT_W'(start_vertex) < active_count) begin
               new_cmd.kind = sgt_pkg::CMD_WALK;
            end else begin
               new_cmd.kind = sgt_pkg::CMD_WALK_BAD;
            end
         end
         default: begin
            // unused opcode is swallowed
            new_ok = 1'b0;
         end
      endcase
   end

   // handshake and queue occupancy
   assign busy    = (fill_ff == (QPW+1)'(QDEPTH));
   assign accept  = start && !busy;
   assign push    = accept && new_ok;
   assign q_valid = (fill_ff != '0);
   assign q_cmd   = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPW+1)'(push) - (QPW+1)'(q_pop);
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue entries
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== rtl/sgt_back.sv =====
// execution back end: neighbor store, edge append and depth-first walk
module sgt_back #(
   parameter int MAX_VERTICES = sgt_pkg::MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = sgt_pkg::MAX_DEGREE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  sgt_pkg::cmd_type              q_cmd,
   output logic                          q_pop,
   input  logic [sgt_pkg::COUNT_W-1:0]   active_count,
   output logic                          rsp_strobe,
   output logic [sgt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sgt_pkg::VERTEX_W-1:0]  rsp_vertex,
   output logic                          rsp_last
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int CW  = $clog2(MAX_DEGREE + 1);
   localparam int SPW = $clog2(MAX_VERTICES + 1);
   localparam int AW  = $clog2(MAX_VERTICES * MAX_DEGREE);

   typedef enum logic [2:0] {
      B_IDLE,
      B_EDGE,
      B_POP,
      B_VTX,
      B_CNT,
      B_SCAN
   } state_type;

   // memories
   logic [sgt_pkg::VERTEX_W-1:0] nbr_mem_ff [MAX_VERTICES*MAX_DEGREE];
   logic [CW-1:0]                cnt_mem_ff [MAX_VERTICES];
   logic [VW-1:0]                stk_mem_ff [MAX_VERTICES];
   logic [sgt_pkg::VERTEX_W-1:0] nbr_rd_ff;
   logic [CW-1:0]                cnt_rd_ff;
   logic [VW-1:0]                stk_rd_ff;

   // memory ports
   logic                         nbr_we;
   logic [AW-1:0]                nbr_waddr, nbr_raddr;
   logic                         cnt_we;
   logic [VW-1:0]                cnt_waddr, cnt_raddr;
   logic [CW-1:0]                cnt_wdata;
   logic                         stk_we;
   logic [VW-1:0]                stk_waddr, stk_raddr, stk_wdata;

   // control state
   state_type                    state_ff, state_in;
   logic [SPW-1:0]               sp_ff, sp_in;
   logic [MAX_VERTICES-1:0]      visited_ff, visited_in;
   logic [MAX_VERTICES-1:0]      cnt_vld_ff, cnt_vld_in;
   logic                         rdv_ff, rdv_in;
   logic                         strobe_ff, strobe_in;

   // working payload
   logic [VW-1:0]                v_ff, v_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [CW-1:0]                idx_ff, idx_in;
   logic [AW-1:0]                base_ff, base_in;
   logic [VW-1:0]                edge_from_ff, edge_from_in;
   logic [sgt_pkg::VERTEX_W-1:0] edge_to_ff, edge_to_in;
   logic [sgt_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [sgt_pkg::VERTEX_W-1:0] vertex_ff, vertex_in;
   logic                         last_ff, last_in;

   logic [CW-1:0]                cur_cnt;
   logic [sgt_pkg::VERTEX_W-1:0] nbr;

   assign cur_cnt   = cnt_vld_ff[edge_from_ff] ? cnt_rd_ff : '0;
   assign nbr       = nbr_rd_ff;
   assign nbr_raddr = base_ff + AW'(idx_ff);
   assign nbr_waddr = AW'(edge_from_ff) * AW'(MAX_DEGREE) + AW'(cur_cnt);
   assign cnt_waddr = edge_from_ff;
   assign cnt_wdata = cur_cnt + CW'(1);
   assign stk_raddr = VW'(sp_ff - SPW'(1));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      visited_in   = visited_ff;
      cnt_vld_in   = cnt_vld_ff;
      rdv_in       = rdv_ff;
      strobe_in    = 1'b0;
      v_in         = v_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      edge_from_in = edge_from_ff;
      edge_to_in   = edge_to_ff;
      status_in    = status_ff;
      vertex_in    = vertex_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      nbr_we       = 1'b0;
      cnt_we       = 1'b0;
      stk_we       = 1'b0;
      stk_waddr    = VW'(sp_ff);
      stk_wdata    = nbr[VW-1:0];
      cnt_raddr    = q_cmd.from_vertex[VW-1:0];

      unique case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  sgt_pkg::CMD_CLEAR: begin
                     cnt_vld_in = '0;
                     strobe_in  = 1'b1;
                     status_in  = sgt_pkg::ST_CLEARED;
                     vertex_in  = '0;
                     last_in    = 1'b1;
                  end
                  sgt_pkg::CMD_EDGE: begin
                     // count read goes out now, decision next cycle
                     edge_from_in = q_cmd.from_vertex[VW-1:0];
                     edge_to_in   = q_cmd.to_vertex;
                     state_in     = B_EDGE;
                  end
                  sgt_pkg::CMD_WALK: begin
                     // push and mark the start vertex
                     visited_in = '0;
                     visited_in[q_cmd.from_vertex[VW-1:0]] = 1'b1;
                     stk_we     = 1'b1;
                     stk_waddr  = '0;
                     stk_wdata  = q_cmd.from_vertex[VW-1:0];
                     sp_in      = SPW'(1);
                     state_in   = B_POP;
                  end
                  default: begin
                     // out of range edge or start vertex
                     strobe_in = 1'b1;
                     status_in = sgt_pkg::ST_DROPPED;
                     vertex_in = '0;
                     last_in   = 1'b1;
                  end
               endcase
            end
         end
         B_EDGE: begin
            strobe_in = 1'b1;
            vertex_in = '0;
            last_in   = 1'b1;
            if (cur_cnt >= CW'(MAX_DEGREE)) begin
               status_in = sgt_pkg::ST_DROPPED;
            end else begin
               nbr_we     = 1'b1;
               cnt_we     = 1'b1;
               cnt_vld_in[edge_from_ff] = 1'b1;
               status_in  = sgt_pkg::ST_STORED;
            end
            state_in = B_IDLE;
         end
         B_POP: begin
            sp_in    = sp_ff - SPW'(1);
            state_in = B_VTX;
         end
         B_VTX: begin
            v_in      = stk_rd_ff;
            cnt_raddr = stk_rd_ff;
            state_in  = B_CNT;
         end
         B_CNT: begin
            cnt_in   = cnt_vld_ff[v_ff] ? cnt_rd_ff : '0;
            base_in  = AW'(v_ff) * AW'(MAX_DEGREE);
            idx_in   = '0;
            rdv_in   = 1'b0;
            state_in = B_SCAN;
         end
         B_SCAN: begin
            // issue one neighbor read per cycle
            if (idx_ff != cnt_ff) begin
               idx_in = idx_ff + CW'(1);
               rdv_in = 1'b1;
            end else begin
               rdv_in = 1'b0;
            end
            // check the neighbor read last cycle, push if fresh
            if (rdv_ff) begin
               if ((sgt_pkg::COUNT_W'(nbr) < active_count) &&
                   !visited_ff[nbr[VW-1:0]]) begin
                  stk_we = 1'b1;
                  sp_in  = sp_ff + SPW'(1);
                  visited_in[nbr[VW-1:0]] = 1'b1;
               end
            end else if (idx_ff == cnt_ff) begin
               // scan done: report the vertex
               strobe_in = 1'b1;
               status_in = sgt_pkg::ST_VISIT;
               vertex_in = sgt_pkg::VERTEX_W'(v_ff);
               last_in   = (sp_ff == '0);
               state_in  = (sp_ff == '0) ? B_IDLE : B_POP;
            end
         end
      endcase
   end

   // state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         sp_ff      <= '0;
         visited_ff <= '0;
         cnt_vld_ff <= '0;
         rdv_ff     <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         sp_ff      <= sp_in;
         visited_ff <= visited_in;
         cnt_vld_ff <= cnt_vld_in;
         rdv_ff     <= rdv_in;
         strobe_ff  <= strobe_in;
      end
      v_ff         <= v_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      base_ff      <= base_in;
      edge_from_ff <= edge_from_in;
      edge_to_ff   <= edge_to_in;
      status_ff    <= status_in;
      vertex_ff    <= vertex_in;
      last_ff      <= last_in;
   end

   // neighbor store
   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem_ff[nbr_waddr] <= edge_to_ff;
      end
      nbr_rd_ff <= nbr_mem_ff[nbr_raddr];
   end

   // neighbor counts
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      cnt_rd_ff <= cnt_mem_ff[cnt_raddr];
   end

   // vertex stack
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem_ff[stk_waddr] <= stk_wdata;
      end
      stk_rd_ff <= stk_mem_ff[stk_raddr];
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_vertex = vertex_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== rtl/stack_graph_traversal_core.sv =====
// top level of the stack graph traversal core: config registers and front/back hookup
//
// A request is taken when start is high and busy is low; a two-entry command
// queue sits between the front end and the execution engine, so busy rises only
// when both entries wait. Responses appear for one cycle on rsp_strobe and cannot
// be held off, so the consumer must take every strobe. Add-edge reads the count
// memory, then appends. A traversal pushes the start vertex, then for each visited
// vertex pops the stack, reads the vertex and its neighbor count, and scans its
// stored neighbors; the neighbor store read port delivers one neighbor a cycle.
// csr_ready is always high; write configuration only when idle.
module stack_graph_traversal_core #(
   parameter int MAX_VERTICES = sgt_pkg::MAX_VERTICES_DEF,
   parameter int MAX_DEGREE   = sgt_pkg::MAX_DEGREE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [sgt_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [sgt_pkg::VERTEX_W-1:0]   req_from_vertex,
   input  logic [sgt_pkg::VERTEX_W-1:0]   req_to_vertex,
   output logic                           rsp_strobe,
   output logic [sgt_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sgt_pkg::VERTEX_W-1:0]   rsp_vertex,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sgt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sgt_pkg::COUNT_W-1:0]    csr_wdata
);

   logic [sgt_pkg::COUNT_W-1:0]  vertex_count_ff, vertex_count_in;
   logic [sgt_pkg::VERTEX_W-1:0] start_vertex_ff, start_vertex_in;
   logic [sgt_pkg::COUNT_W-1:0]  active_count;
   logic                         q_valid;
   logic                         q_pop;
   sgt_pkg::cmd_type             q_cmd;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      vertex_count_in = vertex_count_ff;
      start_vertex_in = start_vertex_ff;
      if (csr_valid) begin
         unique case (sgt_pkg::csr_index_type'(csr_index))
            sgt_pkg::CSR_VERTEX_COUNT: vertex_count_in = csr_wdata;
            sgt_pkg::CSR_START_VERTEX: start_vertex_in = csr_wdata[sgt_pkg::VERTEX_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= sgt_pkg::VERTEX_COUNT_RESET;
         start_vertex_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
         start_vertex_ff <= start_vertex_in;
      end
   end

   // clamp vertex count to the store size
   assign active_count = (vertex_count_ff > sgt_pkg::COUNT_W'(MAX_VERTICES)) ?
                         sgt_pkg::COUNT_W'(MAX_VERTICES) : vertex_count_ff;

   sgt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .active_count    (active_count),
      .start_vertex    (start_vertex_ff),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop)
   );

   sgt_back #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_DEGREE   (MAX_DEGREE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop),
      .active_count (active_count),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_vertex   (rsp_vertex),
      .rsp_last     (rsp_last)
   );

   // busy only while the queue holds commands
   a_busy_has_queue: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_valid)
      else $error("busy asserted with empty command queue");

   // single-response requests always close with last
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != sgt_pkg::ST_VISIT)) |-> rsp_last)
      else $error("non-visit response without last");

   // only visit responses carry a vertex
   a_vertex_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != sgt_pkg::ST_VISIT)) |-> (rsp_vertex == '0))
      else $error("non-visit response with nonzero vertex");

   // popping the queue needs an entry
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command queue popped while empty");

endmodule

// ===== tb/stack_graph_traversal_core_tb.sv =====
// self-checking testbench for the stack graph traversal core with a depth-first order scoreboard
module stack_graph_traversal_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sgt_pkg::*;

   // opcode value the core must ignore
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   localparam int GRAPH_SIZE     = MAX_VERTICES_DEF;
   localparam int LIST_DEPTH     = MAX_DEGREE_DEF;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 30;
   localparam int CYCLE_LIMIT    = 4000000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 50;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      status_type          status;
      logic [VERTEX_W-1:0] vertex;
      logic                last;
   } response_t;

   // mirror of the graph store plus the queue of responses still owed by the core
   class dfs_scoreboard;
      logic [VERTEX_W-1:0] adjacency [GRAPH_SIZE][LIST_DEPTH];
      int unsigned         degree [GRAPH_SIZE];
      bit                  seen [GRAPH_SIZE];
      logic [COUNT_W-1:0]  vertex_count;
      logic [VERTEX_W-1:0] root_vertex;
      response_t           owed [$];
      int unsigned         mismatches;
      int unsigned         responses;
      int unsigned         visits;
      int unsigned         drops;

      function new();
         vertex_count = VERTEX_COUNT_RESET;
         root_vertex  = '0;
         foreach (degree[i]) degree[i] = 0;
         foreach (seen[i]) seen[i] = 1'b0;
         mismatches = 0;
         responses  = 0;
         visits     = 0;
         drops      = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [COUNT_W-1:0] value);
         if (idx == CSR_VERTEX_COUNT) begin
            vertex_count = value;
         end else begin
            root_vertex = value[VERTEX_W-1:0];
         end
      endfunction

      function void owe(status_type status, logic [VERTEX_W-1:0] vertex, logic last);
         response_t r;
         r.status = status;
         r.vertex = vertex;
         r.last   = last;
         owed.push_back(r);
      endfunction

      // work out every response one accepted request causes
      function void take_request(logic [OPCODE_W-1:0] opcode, logic [VERTEX_W-1:0] src,
                                 logic [VERTEX_W-1:0] dst);
         int                  nv;
         logic [VERTEX_W-1:0] stack [$];
         logic [VERTEX_W-1:0] v;
         logic [VERTEX_W-1:0] w;
         // counts above the array size behave as the full array
         nv = (vertex_count > GRAPH_SIZE) ? GRAPH_SIZE : int'(vertex_count);
         case (opcode)
            OP_CLEAR: begin
               foreach (degree[i]) degree[i] = 0;
               owe(ST_CLEARED, '0, 1'b1);
            end
            OP_ADD_EDGE: begin
               if (src >= nv || dst >= nv || degree[src] >= LIST_DEPTH) begin
                  owe(ST_DROPPED, '0, 1'b1);
               end else begin
                  adjacency[src][degree[src]] = dst;
                  degree[src]++;
                  owe(ST_STORED, '0, 1'b1);
               end
            end
            OP_TRAVERSE: begin
               foreach (seen[i]) seen[i] = 1'b0;
               if (root_vertex >= nv) begin
                  owe(ST_DROPPED, '0, 1'b1);
               end else begin
                  stack.push_back(root_vertex);
                  seen[root_vertex] = 1'b1;
                  // pop, emit, then push unvisited neighbors in list order
                  while (stack.size() > 0) begin
                     v = stack.pop_back();
                     owe(ST_VISIT, v, 1'b0);
                     for (int i = 0; i < degree[v]; i++) begin
                        w = adjacency[v][i];
                        // neighbors beyond a lowered vertex count are stale
                        if (w < nv && !seen[w]) begin
                           stack.push_back(w);
                           seen[w] = 1'b1;
                        end
                     end
                  end
                  owed[owed.size()-1].last = 1'b1;
               end
            end
            default: ;
         endcase
      endfunction

      // compare one response strobe against the oldest owed response
      function void match_response(logic [STATUS_W-1:0] status, logic [VERTEX_W-1:0] vertex,
                                   logic last);
         response_t want;
         responses++;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: unexpected response status=%0d vertex=%0d last=%0d",
                        $time, status, vertex, last);
            end
            return;
         end
         want = owed.pop_front();
         if (status !== want.status || vertex !== want.vertex || last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: response mismatch: expected %s vertex=%0d last=%0d",
                        $time, want.status.name(), want.vertex, want.last);
               $display("   got status=%0d vertex=%0d last=%0d", status, vertex, last);
            end
         end
         if (want.status == ST_VISIT) begin
            visits++;
         end else if (want.status == ST_DROPPED) begin
            drops++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OPCODE_W-1:0]   req_opcode;
   logic [VERTEX_W-1:0]   req_from_vertex;
   logic [VERTEX_W-1:0]   req_to_vertex;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [VERTEX_W-1:0]   rsp_vertex;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [COUNT_W-1:0]    csr_wdata;

   dfs_scoreboard board;
   int            idle_pct;
   int unsigned   requests;
   int unsigned   csr_writes;
   int unsigned   cycles;

   stack_graph_traversal_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_vertex      (rsp_vertex),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         board.match_response(rsp_status, rsp_vertex, rsp_last);
      end
   end

   // run-length guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed", cycles,
                  board.owed.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // present one request, with random idle cycles first, and wait for it to be taken
   task automatic issue(logic [OPCODE_W-1:0] opcode, logic [VERTEX_W-1:0] src,
                        logic [VERTEX_W-1:0] dst);
      while ($urandom_range(0, 99) < idle_pct) begin
         start           <= 1'b0;
         req_opcode      <= OPCODE_W'($urandom);
         req_from_vertex <= VERTEX_W'($urandom);
         req_to_vertex   <= VERTEX_W'($urandom);
         @(negedge clock);
      end
      start           <= 1'b1;
      req_opcode      <= opcode;
      req_from_vertex <= src;
      req_to_vertex   <= dst;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      board.take_request(opcode, src, dst);
      requests++;
      @(negedge clock);
   endtask

   // drop start and wait until every owed response has come back
   task automatic settle();
      start <= 1'b0;
      while (board.owed.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one configuration write
   task automatic write_csr(csr_index_type idx, logic [COUNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      board.write_register(idx, value);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // one random phase: new settings, then a mix dominated by in-range edge loads
   task automatic random_phase(int phase);
      int                  nv;
      int                  placed;
      int                  pick;
      logic [COUNT_W-1:0]  count_value;
      logic [VERTEX_W-1:0] root;
      case (phase)
         0: count_value = COUNT_W'(64);
         1: count_value = COUNT_W'($urandom_range(2, 8));
         2: count_value = COUNT_W'(127);
         3: count_value = COUNT_W'(1);
         4: count_value = COUNT_W'($urandom_range(9, 63));
         5: count_value = COUNT_W'(3);
         6: count_value = COUNT_W'($urandom_range(65, 126));
         default: count_value = COUNT_W'($urandom_range(1, 64));
      endcase
      write_csr(CSR_VERTEX_COUNT, count_value);
      nv = (count_value > GRAPH_SIZE) ? GRAPH_SIZE : int'(count_value);
      // start vertex sometimes out of range
      if ($urandom_range(0, 7) == 0) begin
         root = VERTEX_W'($urandom_range(0, 63));
      end else begin
         root = VERTEX_W'($urandom_range(0, nv - 1));
      end
      write_csr(CSR_START_VERTEX, COUNT_W'(root));
      idle_pct = (phase < 3) ? 23 : (phase < 6) ? 51 : 0;
      placed = 0;
      while (placed < PHASE_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            issue(OP_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom));
         end else begin
            if (pick < 7) begin
               issue(OP_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
            end else if (pick < 17) begin
               issue(OP_TRAVERSE, VERTEX_W'($urandom), VERTEX_W'($urandom));
            end else if (pick < 25) begin
               issue(OP_ADD_EDGE, VERTEX_W'($urandom), VERTEX_W'($urandom));
            end else begin
               issue(OP_ADD_EDGE, VERTEX_W'($urandom_range(0, nv - 1)),
                     VERTEX_W'($urandom_range(0, nv - 1)));
            end
            placed++;
         end
      end
      settle();
   endtask

   // stimulus
   initial begin
      int unsigned failed;
      board           = new();
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = OP_CLEAR;
      req_from_vertex = '0;
      req_to_vertex   = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_VERTEX_COUNT;
      csr_wdata       = '0;
      idle_pct        = 23;
      requests        = 0;
      csr_writes      = 0;
      cycles          = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // small graph at full size, field extremes, ignored opcode, walk from vertex 0
      issue(OP_CLEAR, 6'd0, 6'd0);
      issue(OP_ADD_EDGE, 6'd0, 6'd63);
      issue(OP_ADD_EDGE, 6'd63, 6'd0);
      issue(OP_ADD_EDGE, 6'd0, 6'd1);
      issue(OP_ADD_EDGE, 6'd1, 6'd2);
      issue(OP_UNUSED, 6'd63, 6'd63);
      issue(OP_TRAVERSE, 6'd0, 6'd0);
      settle();

      // lowered vertex count: stale neighbors skipped, out-of-range edge dropped, full list
      write_csr(CSR_VERTEX_COUNT, COUNT_W'(2));
      issue(OP_TRAVERSE, 6'd63, 6'd63);
      issue(OP_ADD_EDGE, 6'd0, 6'd2);
      for (int k = 0; k < LIST_DEPTH; k++) begin
         issue(OP_ADD_EDGE, 6'd1, VERTEX_W'(k % 2));
      end
      settle();

      // start vertex out of range
      write_csr(CSR_START_VERTEX, COUNT_W'(63));
      issue(OP_TRAVERSE, 6'd0, 6'd0);
      settle();

      // zero vertices: everything refused
      write_csr(CSR_VERTEX_COUNT, COUNT_W'(0));
      issue(OP_ADD_EDGE, 6'd0, 6'd0);
      issue(OP_TRAVERSE, 6'd0, 6'd0);
      settle();

      // oversized count acts as the full array
      write_csr(CSR_VERTEX_COUNT, COUNT_W'(127));
      issue(OP_TRAVERSE, 6'd0, 6'd0);
      settle();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_phase(phase);
      end

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      failed = board.mismatches + board.owed.size();
      $display("ran %0d requests over %0d register writes; checked %0d responses",
               requests, csr_writes, board.responses);
      $display("walks emitted %0d vertices, %0d edges or walks refused, %0d mismatches",
               board.visits, board.drops, board.mismatches);
      if (failed == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
